// ===== hdl/dsmr_pkg.sv =====
// shared types and constants for the dual sensor mouse report unit
package dsmr_pkg;

    // sqrt(2) scaled by 2^34, good enough that floor(mag * sqrt2) comes out exact
    localparam int SQRT2_SHIFT = 34;
    localparam logic [34:0] SQRT2_Q34 = 35'd24296004000;

    // fraction bits of the reciprocal used to divide by the scroll tick
    localparam int RECIP_SHIFT = 24;

    // one poll from the sensors, last field in the lowest bits
    typedef struct packed {
        logic               host_suspended;
        logic [2:0]         buttons_down;
        logic signed [15:0] sensor2_dy;
        logic signed [15:0] sensor2_dx;
        logic signed [15:0] sensor1_dy;
        logic signed [15:0] sensor1_dx;
    } poll_t;

    // one report to the host, last field in the lowest bits
    typedef struct packed {
        logic               tick_click;
        logic               wake_host;
        logic signed [7:0]  wheel;
        logic signed [7:0]  move_y;
        logic signed [7:0]  move_x;
        logic [2:0]         button_mask;
    } out_rpt_t;

    // front stage results: rotation product and pre-divided scroll amount
    typedef struct packed {
        logic [15:0]        rot_floor;
        logic               rot_pos;
        logic               rot_zero;
        logic signed [15:0] move_y;
        logic               scroll;
        logic signed [16:0] raw;
        logic               raw_neg;
        logic [15:0]        raw_mag;
        logic [15:0]        raw_quot;
        logic [2:0]         buttons;
        logic               suspended;
    } front_t;

    // middle stage results: final motion and signed split of the scroll amount
    typedef struct packed {
        logic signed [7:0]  move_x;
        logic signed [7:0]  move_y;
        logic signed [7:0]  wheel;
        logic               motion_nz;
        logic               scroll;
        logic signed [16:0] raw;
        logic signed [16:0] raw_quot;
        logic signed [8:0]  raw_rem;
        logic [2:0]         buttons;
        logic               suspended;
    } mid_t;

    // magnitude of a 16 bit signed value; the most negative value maps to 2^15
    function automatic logic [15:0] abs16(input logic signed [15:0] v);
        return v[15] ? 16'(-v) : 16'(v);
    endfunction

endpackage

// ===== hdl/dsmr_front.sv =====
// front stage: scroll detection, rotation multiply and reciprocal multiply
module dsmr_front #(
    parameter int WHEEL_DETENT = 128
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  dsmr_pkg::poll_t  in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output dsmr_pkg::front_t out_data
);

    localparam logic [dsmr_pkg::RECIP_SHIFT-1:0] RECIP =
        dsmr_pkg::RECIP_SHIFT'(((64'd1 << dsmr_pkg::RECIP_SHIFT) + WHEEL_DETENT - 1)
                               / WHEEL_DETENT);
    localparam int PW = 16 + dsmr_pkg::RECIP_SHIFT;

    logic             valid_reg;
    logic             valid_next;
    dsmr_pkg::front_t data_reg;
    dsmr_pkg::front_t data_next;
    logic             load;

    logic [15:0]        ax1, ay1, ax2, ay2;
    logic [50:0]        rot_prod;
    logic signed [16:0] dy_sum;
    logic signed [16:0] dy_adj;
    logic signed [16:0] half;
    logic signed [16:0] raw;
    logic [15:0]        raw_mag;
    logic [PW-1:0]      div_prod;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // axis magnitudes on both sensors, used by the mostly-vertical test
    always_comb begin
        ax1 = dsmr_pkg::abs16(in_data.sensor1_dx);
        ay1 = dsmr_pkg::abs16(in_data.sensor1_dy);
        ax2 = dsmr_pkg::abs16(in_data.sensor2_dx);
        ay2 = dsmr_pkg::abs16(in_data.sensor2_dy);
    end

    // rotation: floor(sqrt2 * |dx2|)
    assign rot_prod = 51'(ax2) * 51'(dsmr_pkg::SQRT2_Q34);

    // averaged scroll amount, negated, rounded toward zero
    always_comb begin
        dy_sum  = {in_data.sensor1_dy[15], in_data.sensor1_dy}
                + {in_data.sensor2_dy[15], in_data.sensor2_dy};
        dy_adj  = dy_sum + 17'({16'd0, dy_sum[16]});
        half    = dy_adj >>> 1;
        raw     = 17'sd0 - half;
        raw_mag = raw[16] ? 16'(-raw) : raw[15:0];
    end

    // quotient of the scroll magnitude by the tick, via reciprocal
    assign div_prod = PW'(raw_mag) * PW'(RECIP);

    // next contents of the stage register
    always_comb begin
        data_next.rot_floor = rot_prod[dsmr_pkg::SQRT2_SHIFT +: 16];
        data_next.rot_pos   = in_data.sensor2_dx[15];
        data_next.rot_zero  = (in_data.sensor2_dx == 16'sd0);
        data_next.move_y    = in_data.sensor1_dx;
        data_next.scroll    = ({1'b0, ay1} > {ax1, 1'b0}) && ({1'b0, ay2} > {ax2, 1'b0});
        data_next.raw       = raw;
        data_next.raw_neg   = raw[16];
        data_next.raw_mag   = raw_mag;
        data_next.raw_quot  = div_prod[dsmr_pkg::RECIP_SHIFT +: 16];
        data_next.buttons   = in_data.buttons_down;
        data_next.suspended = in_data.host_suspended;
    end

    // stage valid
    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hdl/dsmr_mid.sv =====
// middle stage: pointer x from the rotated sensor, signed split of the scroll amount
module dsmr_mid #(
    parameter int WHEEL_DETENT = 128
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  dsmr_pkg::front_t in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output dsmr_pkg::mid_t   out_data
);

    logic           valid_reg;
    logic           valid_next;
    dsmr_pkg::mid_t data_reg;
    dsmr_pkg::mid_t data_next;
    logic           load;

    logic signed [17:0] y_ext;
    logic signed [17:0] f_ext;
    logic signed [17:0] base_p;
    logic signed [17:0] base_n;
    logic signed [17:0] x_full;
    logic [23:0]        tick_prod;
    logic [15:0]        rem_mag;
    logic signed [8:0]  rem_pos;
    logic signed [16:0] quot_pos;

    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    // x = trunc(sqrt2 * s - y), s = -dx2, value never lands on an integer when s != 0
    always_comb begin
        y_ext  = {{2{in_data.move_y[15]}}, in_data.move_y};
        f_ext  = {2'b00, in_data.rot_floor};
        base_p = f_ext - y_ext;
        base_n = 18'sd0 - f_ext - y_ext;
        priority if (in_data.rot_zero) begin
            x_full = 18'sd0 - y_ext;
        end else if (in_data.rot_pos) begin
            x_full = base_p[17] ? base_p + 18'sd1 : base_p;
        end else begin
            x_full = (!base_n[17] && base_n != 18'sd0) ? base_n - 18'sd1 : base_n;
        end
    end

    // remainder of the scroll magnitude, then signs restored
    always_comb begin
        tick_prod = 24'(in_data.raw_quot) * 24'(WHEEL_DETENT);
        rem_mag   = in_data.raw_mag - tick_prod[15:0];
        rem_pos   = {1'b0, rem_mag[7:0]};
        quot_pos  = {1'b0, in_data.raw_quot};
    end

    // next contents of the stage register
    always_comb begin
        data_next.move_x    = in_data.scroll ? 8'sd0 : x_full[7:0];
        data_next.move_y    = in_data.scroll ? 8'sd0 : in_data.move_y[7:0];
        data_next.wheel     = in_data.scroll ? in_data.raw[7:0] : 8'sd0;
        data_next.motion_nz = !in_data.scroll
                              && (x_full != 18'sd0 || in_data.move_y != 16'sd0);
        data_next.scroll    = in_data.scroll;
        data_next.raw       = in_data.raw;
        data_next.raw_quot  = in_data.raw_neg ? 17'sd0 - quot_pos : quot_pos;
        data_next.raw_rem   = in_data.raw_neg ? 9'sd0 - rem_pos : rem_pos;
        data_next.buttons   = in_data.buttons;
        data_next.suspended = in_data.suspended;
    end

    // stage valid
    always_comb begin
        if (load) begin
            valid_next = 1'b1;
        end else if (out_ready) begin
            valid_next = 1'b0;
        end else begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== hdl/dsmr_report.sv =====
// report stage: scroll remainder, button latch, report decision and output register
module dsmr_report #(
    parameter int WHEEL_DETENT = 128
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  dsmr_pkg::mid_t     in_data,
    output logic               m_valid,
    input  logic               m_ready,
    output dsmr_pkg::out_rpt_t m_data
);

    localparam logic signed [9:0] TK = 10'(WHEEL_DETENT);

    logic signed [7:0]  rem_reg;
    logic signed [7:0]  rem_next;
    logic [2:0]         btn_reg;
    logic               m_valid_reg;
    logic               m_valid_next;
    dsmr_pkg::out_rpt_t m_data_reg;
    dsmr_pkg::out_rpt_t m_data_next;
    logic               consume;

    logic signed [17:0] acc;
    logic signed [9:0]  part;
    logic signed [9:0]  rem_new;
    logic signed [2:0]  adj;
    logic signed [17:0] quot;
    logic               quot_nz;
    logic               changed;
    logic               report;

    assign in_ready = !m_valid_reg || m_ready;
    assign consume  = in_valid && in_ready;

    // combine carried remainder with the pre-split scroll amount
    always_comb begin
        acc  = {in_data.raw[16], in_data.raw} + {{10{rem_reg[7]}}, rem_reg};
        part = {in_data.raw_rem[8], in_data.raw_rem} + {{2{rem_reg[7]}}, rem_reg};
        if (!acc[17]) begin
            // remainder must land in [0, tick)
            priority if (part >= TK) begin
                adj = 3'sd1;
                rem_new = part - TK;
            end else if (part >= 10'sd0) begin
                adj = 3'sd0;
                rem_new = part;
            end else if (part >= -TK) begin
                adj = -3'sd1;
                rem_new = part + TK;
            end else begin
                adj = -3'sd2;
                rem_new = part + TK + TK;
            end
        end else begin
            // remainder must land in (-tick, 0]
            priority if (part <= -TK) begin
                adj = -3'sd1;
                rem_new = part + TK;
            end else if (part <= 10'sd0) begin
                adj = 3'sd0;
                rem_new = part;
            end else if (part <= TK) begin
                adj = 3'sd1;
                rem_new = part - TK;
            end else begin
                adj = 3'sd2;
                rem_new = part - TK - TK;
            end
        end
        quot    = {in_data.raw_quot[16], in_data.raw_quot} + {{15{adj[2]}}, adj};
        quot_nz = in_data.scroll && (quot != 18'sd0);
        rem_next = in_data.scroll ? rem_new[7:0] : rem_reg;
    end

    // report decision and payload
    always_comb begin
        changed = (in_data.buttons != btn_reg);
        report  = in_data.motion_nz || quot_nz || changed;
        m_data_next.button_mask = in_data.buttons;
        m_data_next.move_x      = in_data.move_x;
        m_data_next.move_y      = in_data.move_y;
        m_data_next.wheel       = in_data.wheel;
        m_data_next.wake_host   = changed && in_data.suspended;
        m_data_next.tick_click  = quot_nz;
    end

    // output valid
    always_comb begin
        if (consume) begin
            m_valid_next = report;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            rem_reg     <= 8'sd0;
            btn_reg     <= 3'd0;
        end else begin
            m_valid_reg <= m_valid_next;
            if (consume) begin
                rem_reg <= rem_next;
                btn_reg <= in_data.buttons;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (consume && report) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a button change always produces a report
    a_change_reports: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && changed |=> m_valid_reg)
        else $error("button change did not produce a report");

    // remainder only moves on scroll polls
    a_rem_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        consume && !in_data.scroll |=> rem_reg == $past(rem_reg))
        else $error("scroll remainder changed outside scroll mode");

    // a wheel tick comes only from a scroll poll, which carries no motion
    a_click_no_motion: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_data_reg.tick_click |->
            m_data_reg.move_x == 8'sd0 && m_data_reg.move_y == 8'sd0)
        else $error("tick click reported together with pointer motion");

endmodule

// ===== hdl/dual_sensor_mouse_report_unit.sv =====
// top level of the dual sensor mouse report unit
//
// Takes one sensor poll per request on the s_ channel: two optical sensor
// deltas, the pressed button mask and the host suspend flag. Each poll yields
// at most one report on the m_ channel: buttons, pointer x/y, wheel amount,
// remote wakeup and a click pulse for the piezo. Polls with no motion, no
// wheel tick and no button change produce no report at all.
// An accepted poll passes through these stages in order to its report on m_tvalid:
// a front stage holding the two multipliers (sqrt2 rotation and reciprocal of
// the scroll tick), a middle stage finishing pointer x and the signed split of
// the scroll amount, and the report stage where the scroll remainder and the
// button latch live. The remainder update is a single add and select loop, so
// one poll per cycle is taken for as long as the receiver keeps up.
// Reset (aresetn low at a clock edge) empties the pipeline, clears the scroll
// remainder and releases all latched buttons.
// When m_tready is low the report is held and the stages fill behind it; the
// front and middle registers absorb two more polls before s_tready drops.
module dual_sensor_mouse_report_unit #(
    parameter int WHEEL_DETENT = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // sensor1_dx, sensor1_dy, sensor2_dx, sensor2_dy, buttons_down, host_suspended, pad
    input  logic [71:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // button_mask, move_x, move_y, wheel, wake_host, tick_click, pad
    output logic [31:0] m_tdata
);

    dsmr_pkg::poll_t    poll;
    dsmr_pkg::front_t   front_data;
    dsmr_pkg::mid_t     mid_data;
    dsmr_pkg::out_rpt_t rpt;
    logic               front_valid;
    logic               front_ready;
    logic               mid_valid;
    logic               mid_ready;

    assign poll = dsmr_pkg::poll_t'(s_tdata[$bits(dsmr_pkg::poll_t)-1:0]);

    dsmr_front #(
        .WHEEL_DETENT(WHEEL_DETENT)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (poll),
        .out_valid (front_valid),
        .out_ready (front_ready),
        .out_data  (front_data)
    );

    dsmr_mid #(
        .WHEEL_DETENT(WHEEL_DETENT)
    ) u_mid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (front_valid),
        .in_ready  (front_ready),
        .in_data   (front_data),
        .out_valid (mid_valid),
        .out_ready (mid_ready),
        .out_data  (mid_data)
    );

    dsmr_report #(
        .WHEEL_DETENT(WHEEL_DETENT)
    ) u_report (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (mid_valid),
        .in_ready (mid_ready),
        .in_data  (mid_data),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_data   (rpt)
    );

    // report packed into the byte-aligned data bus
    assign m_tdata = {(32 - $bits(dsmr_pkg::out_rpt_t))'(0), rpt};

    // the input side only stalls behind a held report
    a_stall_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled while the report register was free");

    // a report only follows an earlier poll
    a_report_after_poll: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(mid_valid))
        else $error("report raised without a poll in the last stage");

endmodule
